// ----- sv/reader_slot_registry_min_horizon_macros.svh -----
// assertion macros for the reader slot registry
`ifndef READER_SLOT_REGISTRY_MIN_HORIZON_MACROS_SVH
`define READER_SLOT_REGISTRY_MIN_HORIZON_MACROS_SVH

// same-cycle implication, checked outside reset
`define RSRMH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define RSRMH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rsrmh_pkg.sv -----
// shared types and constants for the reader slot registry
`timescale 1ns / 1ps
package rsrmh_pkg;

	localparam int READERS_DEF = 64;
	localparam int BOUND_W     = 64;
	localparam int SLOT_W      = 6;

	typedef enum logic [1:0] {
		MODE_REGISTER   = 2'd0,
		MODE_UNREGISTER = 2'd1,
		MODE_QUERY      = 2'd2
	} mode_t;

	typedef enum logic {
		STATUS_OK      = 1'b0,
		STATUS_NO_FREE = 1'b1
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		mode_t               mode;
		logic [BOUND_W-1:0]  bound;
		logic [SLOT_W-1:0]   slot_index;
		logic [BOUND_W-1:0]  txn_floor;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   granted_slot;
		logic [BOUND_W-1:0]  horizon;
	} rsp_t;

	// control group towards the slot memories
	typedef struct packed {
		logic rd_en;
		logic used_we;
		logic used_wd;
		logic bound_we;
	} mem_ctl_t;

endpackage

// ----- sv/reader_slot_registry_min_horizon.sv -----
// top level of the reader slot registry with minimum horizon tracking
`timescale 1ns / 1ps
// Reader slot registry. Each of READERS slots keeps a used mark and a 64-bit
// visibility bound in two synchronous memories. After reset a clearing pass
// walks the used-mark memory, one slot a cycle, and busy stays high until every
// slot is wiped. A request is taken when start is
// high and busy is low; its single result shows on rsp for exactly one cycle
// with done high, and must be captured then since there is no back-pressure.
// Register and query requests go through a scan of the memories, one slot a
// cycle over the shared read port: a register stops at the lowest free slot
// and strobes done there, while a full registry and any horizon query strobe
// done only after the last slot has been read.
// Unregister and unknown-mode requests write at most one used mark at the
// accepting edge and strobe done in the next cycle, and busy stays low, so
// they may follow one another every cycle. busy drops in the cycle that
// carries a scan's result, so the next request can be taken there.
// granted_slot carries the low six bits of the slot number.
module reader_slot_registry_min_horizon #(
	parameter int READERS = rsrmh_pkg::READERS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  rsrmh_pkg::req_t req,
	output logic            done,
	output rsrmh_pkg::rsp_t rsp
);
	import rsrmh_pkg::*;

`include "reader_slot_registry_min_horizon_macros.svh"

	localparam int AW = (READERS > 1) ? $clog2(READERS) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(READERS - 1);

	// control state
	state_t        state_q, state_d;
	logic [AW-1:0] ptr_q;        // clearing pass address, then scan read address
	logic          issue_done_q; // last scan read already issued
	logic          vld_s1;       // read data valid this cycle
	logic [AW-1:0] addr_s1;      // slot whose data is on the read port
	logic          done_q;

	// payload captured at transfer
	mode_t              op_q;
	logic [BOUND_W-1:0] bound_q;
	logic [BOUND_W-1:0] min_q;
	rsp_t               rsp_q;

	// memory side
	mem_ctl_t           mem_ctl;
	logic [AW-1:0]      wr_addr;
	logic               rd_used;
	logic [BOUND_W-1:0] rd_bound;

	// decode
	logic               take;
	logic               idx_ok;
	logic               hit_free;
	logic               last_s1;
	logic               finish;
	logic [BOUND_W-1:0] min_next;
	logic               done_d;
	rsp_t               rsp_d;

	assign busy   = (state_q != ST_IDLE);
	assign take   = start && (state_q == ST_IDLE);
	assign idx_ok = (32'(req.slot_index) < READERS);

	// scan decisions on the returned slot
	assign hit_free = (op_q == MODE_REGISTER) && !rd_used;
	assign last_s1  = (addr_s1 == LAST_SLOT);
	assign finish   = (state_q == ST_SCAN) && vld_s1 && (hit_free || last_s1);
	assign min_next = (rd_used && (rd_bound < min_q)) ? rd_bound : min_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (ptr_q == LAST_SLOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (take && ((req.mode == MODE_REGISTER) || (req.mode == MODE_QUERY))) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// memory control and result forming
	always_comb begin
		mem_ctl  = '0;
		wr_addr  = ptr_q;
		done_d   = 1'b0;
		rsp_d    = '0;
		case (state_q)
			ST_CLEAR: begin
				// wipe one used mark per cycle
				mem_ctl.used_we = 1'b1;
				mem_ctl.used_wd = 1'b0;
			end
			ST_IDLE: begin
				if (take) begin
					case (req.mode)
						MODE_UNREGISTER: begin
							// out-of-range slots are ignored
							mem_ctl.used_we = idx_ok;
							mem_ctl.used_wd = 1'b0;
							wr_addr         = AW'(req.slot_index);
							done_d          = 1'b1;
						end
						MODE_REGISTER, MODE_QUERY: begin
							done_d = 1'b0;
						end
						default: begin
							// unknown mode: empty result
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				mem_ctl.rd_en = !issue_done_q;
				wr_addr       = addr_s1;
				if (finish) begin
					done_d = 1'b1;
					if (op_q == MODE_REGISTER) begin
						if (hit_free) begin
							mem_ctl.used_we    = 1'b1;
							mem_ctl.used_wd    = 1'b1;
							mem_ctl.bound_we   = 1'b1;
							rsp_d.status       = STATUS_OK;
							rsp_d.granted_slot = SLOT_W'(addr_s1);
						end else begin
							rsp_d.status = STATUS_NO_FREE;
						end
					end else begin
						rsp_d.horizon = min_next;
					end
				end
			end
			default: begin
				mem_ctl = '0;
			end
		endcase
	end

	rsrmh_slot_mem #(
		.READERS (READERS),
		.AW      (AW)
	) u_slot_mem (
		.clk      (clk),
		.ctl      (mem_ctl),
		.wr_addr  (wr_addr),
		.wr_bound (bound_q),
		.rd_addr  (ptr_q),
		.rd_used  (rd_used),
		.rd_bound (rd_bound)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			ptr_q        <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= mem_ctl.rd_en;
			done_q  <= done_d;
			if (state_q == ST_CLEAR) begin
				ptr_q <= ptr_q + AW'(1);
			end else if (take) begin
				ptr_q        <= '0;
				issue_done_q <= 1'b0;
			end else if (mem_ctl.rd_en) begin
				ptr_q <= ptr_q + AW'(1);
				if (ptr_q == LAST_SLOT) begin
					issue_done_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
		rsp_q   <= rsp_d;
		if (take) begin
			op_q    <= req.mode;
			bound_q <= req.bound;
			min_q   <= req.txn_floor;
		end else if ((state_q == ST_SCAN) && vld_s1) begin
			min_q <= min_next;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// checks
	`RSRMH_ASSERT_IMP(a_full_clean, clk, arst_n, done && (rsp.status == STATUS_NO_FREE), (rsp.granted_slot == '0) && (rsp.horizon == '0), "full registry result carries data")
	`RSRMH_ASSERT_NXT(a_scan_busy, clk, arst_n, take && ((req.mode == MODE_REGISTER) || (req.mode == MODE_QUERY)), busy && !done, "scan request did not hold busy")
	`RSRMH_ASSERT_NXT(a_no_reclear, clk, arst_n, state_q != ST_CLEAR, state_q != ST_CLEAR, "clearing pass restarted")
	`RSRMH_ASSERT_IMP(a_scan_addr, clk, arst_n, vld_s1 && (state_q == ST_SCAN), 32'(addr_s1) < READERS, "scan read beyond last slot")

endmodule

// ----- sv/rsrmh_slot_mem.sv -----
// slot memories: used marks and visibility bounds, one write and one read a cycle
`timescale 1ns / 1ps
module rsrmh_slot_mem #(
	parameter int READERS = rsrmh_pkg::READERS_DEF,
	parameter int AW      = (READERS > 1) ? $clog2(READERS) : 1
) (
	input  logic                          clk,
	input  rsrmh_pkg::mem_ctl_t           ctl,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [rsrmh_pkg::BOUND_W-1:0] wr_bound,
	input  logic [AW-1:0]                 rd_addr,
	output logic                          rd_used,
	output logic [rsrmh_pkg::BOUND_W-1:0] rd_bound
);
	import rsrmh_pkg::*;

	logic               used_mem  [READERS];
	logic [BOUND_W-1:0] bound_mem [READERS];

	always_ff @(posedge clk) begin
		if (ctl.used_we) begin
			used_mem[wr_addr] <= ctl.used_wd;
		end
		if (ctl.rd_en) begin
			rd_used <= used_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.bound_we) begin
			bound_mem[wr_addr] <= wr_bound;
		end
		if (ctl.rd_en) begin
			rd_bound <= bound_mem[rd_addr];
		end
	end

endmodule
